### hw/rtl/two_segment_packet_framer_defines.svh
// Assertion macros for the two-segment packet framer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TWO_SEGMENT_PACKET_FRAMER_DEFINES_SVH
`define TWO_SEGMENT_PACKET_FRAMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSPF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed");

// Consequent must hold in the cycle after the antecedent.
`define TSPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed");

`endif

### hw/rtl/tspf_pkg.sv
// Shared types and constants of the two-segment packet framer.
// No dependencies; used by every framer module.
`default_nettype none

package tspf_pkg;

    // Input item kinds carried on the slave-side tuser bit.
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // Framing marker bytes.
    localparam logic [7:0] MARK_SEG1_START = 8'hF0;
    localparam logic [7:0] MARK_SEG1_END   = 8'hF1;
    localparam logic [7:0] MARK_SEG2_START = 8'hF2;
    localparam logic [7:0] MARK_SEG2_END   = 8'hF3;
    localparam logic [7:0] MARK_CLOSE      = 8'hFD;

    // The closing marker pair is counted into the checksum ahead of time.
    localparam logic [7:0] CHECK_BIAS = 8'(2 * MARK_CLOSE);

    // One job for the back end: a head part (start header or one data byte),
    // optionally followed by the middle framing, the packet tail or both.
    typedef struct packed {
        logic        is_start;
        logic        do_mid;
        logic        do_tail;
        logic [7:0]  lead_byte;   // packet type for a start, payload for data
        logic [7:0]  mode_byte;
        logic [15:0] length_one;
        logic [15:0] length_two;
    } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/tspf_front.sv
// Front end of the framer: tracks the packet phase and turns each accepted start
// beat or in-segment data beat into one job for the back end. Depends on tspf_pkg.
`default_nettype none

module tspf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_accept,
    input  wire logic          opcode,
    input  wire logic [7:0]    packet_type,
    input  wire logic [7:0]    mode_byte,
    input  wire logic [15:0]   length_one,
    input  wire logic [15:0]   length_two,
    input  wire logic [7:0]    data_byte,
    output logic               push,
    output tspf_pkg::cmd_t     cmd
);
    import tspf_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEG1 = 2'd1;
    localparam logic [1:0] PH_SEG2 = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] saved_reg, saved_next;
    logic [15:0] left_dec;

    assign left_dec = left_reg - 16'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        left_next      = left_reg;
        saved_next     = saved_reg;
        push           = 1'b0;
        cmd.is_start   = 1'b0;
        cmd.do_mid     = 1'b0;
        cmd.do_tail    = 1'b0;
        cmd.lead_byte  = data_byte;
        cmd.mode_byte  = mode_byte;
        cmd.length_one = length_one;
        cmd.length_two = saved_reg;
        if (in_accept)
        begin
            if (opcode == OP_START)
            begin
                push           = 1'b1;
                cmd.is_start   = 1'b1;
                cmd.lead_byte  = packet_type;
                cmd.length_two = length_two;
                saved_next     = length_two;
                if (length_one == 16'd0)
                begin
                    cmd.do_mid = 1'b1;
                    if (length_two == 16'd0)
                    begin
                        cmd.do_tail = 1'b1;
                        phase_next  = PH_IDLE;
                        left_next   = 16'd0;
                    end
                    else
                    begin
                        phase_next = PH_SEG2;
                        left_next  = length_two;
                    end
                end
                else
                begin
                    phase_next = PH_SEG1;
                    left_next  = length_one;
                end
            end
            else if (phase_reg inside {PH_SEG1, PH_SEG2})
            begin
                // Data beats outside a segment are dropped without a job.
                push      = 1'b1;
                left_next = left_dec;
                if (left_dec == 16'd0)
                begin
                    if (phase_reg == PH_SEG1)
                    begin
                        cmd.do_mid = 1'b1;
                        if (saved_reg == 16'd0)
                        begin
                            cmd.do_tail = 1'b1;
                            phase_next  = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_SEG2;
                            left_next  = saved_reg;
                        end
                    end
                    else
                    begin
                        cmd.do_tail = 1'b1;
                        phase_next  = PH_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= 16'd0;
            saved_reg <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            saved_reg <= saved_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tspf_queue.sv
// Small job queue between the framer front and back ends.
// Depends on tspf_pkg for the job type.
`default_nettype none

module tspf_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  tspf_pkg::cmd_t     push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output tspf_pkg::cmd_t     head_cmd
);
    import tspf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tspf_back.sv
// Back end of the framer: expands the job at the queue head into packet bytes,
// keeps the running checksum and drives the output register. Depends on tspf_pkg.
`default_nettype none

module tspf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  tspf_pkg::cmd_t     head_cmd,
    output logic               pop,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [7:0]         out_byte,
    output logic               out_last
);
    import tspf_pkg::*;

    localparam logic [1:0] SEG_HEAD = 2'd0;
    localparam logic [1:0] SEG_MID  = 2'd1;
    localparam logic [1:0] SEG_TAIL = 2'd2;

    logic [1:0] seg_reg, seg_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] sum_reg, sum_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       advance;
    logic [7:0] sum_base;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       seg_done;
    logic [2:0] seg_end;

    assign advance  = head_valid && (!valid_reg || out_ready);
    // A start header opens a fresh checksum.
    assign sum_base = (seg_reg == SEG_HEAD && idx_reg == 3'd0 && head_cmd.is_start)
                      ? 8'd0 : sum_reg;

    always_comb
    begin
        cur_byte = 8'd0;
        cur_last = 1'b0;
        seg_end  = 3'd0;
        case (seg_reg)
            SEG_HEAD:
            begin
                if (head_cmd.is_start)
                begin
                    seg_end = 3'd5;
                    case (idx_reg)
                        3'd0, 3'd1: cur_byte = head_cmd.lead_byte;
                        3'd2:       cur_byte = head_cmd.mode_byte;
                        3'd3:       cur_byte = MARK_SEG1_START;
                        3'd4:       cur_byte = head_cmd.length_one[7:0];
                        default:    cur_byte = head_cmd.length_one[15:8];
                    endcase
                end
                else
                begin
                    cur_byte = head_cmd.lead_byte;
                end
            end
            SEG_MID:
            begin
                seg_end = 3'd3;
                case (idx_reg)
                    3'd0:    cur_byte = MARK_SEG1_END;
                    3'd1:    cur_byte = MARK_SEG2_START;
                    3'd2:    cur_byte = head_cmd.length_two[7:0];
                    default: cur_byte = head_cmd.length_two[15:8];
                endcase
            end
            default:
            begin
                seg_end = 3'd7;
                case (idx_reg)
                    3'd0:                   cur_byte = MARK_SEG2_END;
                    3'd1, 3'd2, 3'd3, 3'd4: cur_byte = 8'd0;
                    3'd5:                   cur_byte = sum_base + CHECK_BIAS;
                    default:                cur_byte = MARK_CLOSE;
                endcase
                cur_last = (idx_reg == 3'd7);
            end
        endcase
    end

    assign seg_done = (idx_reg == seg_end);

    always_comb
    begin
        seg_next   = seg_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        valid_next = valid_reg;
        pop        = 1'b0;
        if (advance)
        begin
            valid_next = 1'b1;
            sum_next   = sum_base + cur_byte;
            if (!seg_done)
            begin
                idx_next = idx_reg + 3'd1;
            end
            else
            begin
                idx_next = 3'd0;
                if (seg_reg == SEG_HEAD && head_cmd.do_mid)
                begin
                    seg_next = SEG_MID;
                end
                else if (seg_reg != SEG_TAIL && head_cmd.do_tail)
                begin
                    seg_next = SEG_TAIL;
                end
                else
                begin
                    seg_next = SEG_HEAD;
                    pop      = 1'b1;
                end
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg   <= SEG_HEAD;
            idx_reg   <= 3'd0;
            sum_reg   <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg   <= seg_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= cur_byte;
            last_reg <= cur_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

### hw/rtl/two_segment_packet_framer.sv
// Two-segment packet framer, top level: front end, job queue and back end.
// Reset is asynchronous. Jobs are registered in the queue, bytes in the output
// register. Throughput: one byte per cycle while the consumer is ready, set by the
// back-end byte sequencer; a start beat yields 6 to 18 bytes, a data beat 1 to 13.
// Input beats are taken each cycle while the QUEUE_DEPTH-entry job queue has room.
// Depends on tspf_pkg, tspf_front, tspf_queue, tspf_back and the defines header.
`default_nettype none
`include "two_segment_packet_framer_defines.svh"

module two_segment_packet_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input beats.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata, low bit up: packet_type[7:0], mode_byte[15:8], length_one[31:16],
    // length_two[47:32], data_byte[55:48].
    input  wire logic [55:0] s_axis_tdata,
    // tuser: opcode (0 = start of packet, 1 = one data byte).
    input  wire logic        s_axis_tuser,
    // Output beats.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: out_byte[7:0].
    output logic [7:0]       m_axis_tdata,
    // tlast: end_of_packet, set on the final closing marker byte.
    output logic             m_axis_tlast
);
    import tspf_pkg::*;

    logic in_accept;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_head_valid;
    cmd_t front_cmd;
    cmd_t head_cmd;

    // The front end never waits on the back end; it stalls only when the
    // queue is full.
    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // The front end follows the segment byte counts and decides, per beat,
    // which framing pieces the back end has to add.
    tspf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .opcode      (s_axis_tuser),
        .packet_type (s_axis_tdata[7:0]),
        .mode_byte   (s_axis_tdata[15:8]),
        .length_one  (s_axis_tdata[31:16]),
        .length_two  (s_axis_tdata[47:32]),
        .data_byte   (s_axis_tdata[55:48]),
        .push        (q_push),
        .cmd         (front_cmd)
    );

    tspf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (front_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_cmd   (head_cmd)
    );

    // The back end walks the head job byte by byte and holds the result in
    // an output register; a stalled consumer blocks the front once the queue fills.
    tspf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

    // A packet always ends on the closing marker.
    `TSPF_ASSERT_SAME(a_last_is_close, m_axis_tvalid && m_axis_tlast, m_axis_tdata == MARK_CLOSE)
    // The front end only writes the queue when there is room.
    `TSPF_ASSERT_SAME(a_no_push_when_full, q_push, !q_full)
    // A pending job with a free output slot always produces a beat.
    `TSPF_ASSERT_NEXT(a_back_moves, q_head_valid && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid)

endmodule

`default_nettype wire

### bench/two_segment_packet_framer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for two_segment_packet_framer: random and directed beats are
// framed by an in-bench predictor and compared byte by byte with the output stream.
// Depends on tspf_pkg and the two_segment_packet_framer RTL only.

module two_segment_packet_framer_tb;
    import tspf_pkg::*;

    localparam int LONG_HOLD   = 400;   // receiver hold-off used to back the block up
    localparam int TAIL_CYCLES = 20;    // quiet cycles after the last byte due has arrived
    localparam int PHASE_BEATS = 50;    // counted beats per traffic phase

    // Traffic profiles: which side inserts gaps while a beat is in flight.
    typedef enum logic [1:0] {
        PROF_STEADY,
        PROF_SENDER_GAPS,
        PROF_RECEIVER_STALLS,
        PROF_BOTH
    } traffic_e;

    // Packet position of the framer as the predictor tracks it.
    typedef enum logic [1:0] {
        SEG_IDLE,
        SEG_ONE,
        SEG_TWO
    } segment_e;

    typedef struct {
        logic        wait_drain;   // hold this beat back until all bytes due have arrived
        logic        hold_output;  // ask the receiver for a long hold-off
        traffic_e    traffic;
        logic        opcode;
        logic [7:0]  packet_type;
        logic [7:0]  mode_byte;
        logic [15:0] length_one;
        logic [15:0] length_two;
        logic [7:0]  data_byte;
    } beat_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    beat_t       pending_beats[$];
    frame_byte_t frame_bytes_due[$];
    beat_t       offered;
    traffic_e    traffic = PROF_STEADY;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          mismatch_count = 0;

    // Predictor state.
    segment_e    frm_segment = SEG_IDLE;
    logic [15:0] frm_left = '0;
    logic [15:0] frm_len_two = '0;
    logic [7:0]  frm_sum = '0;

    traffic_e    phase_order [4] = '{PROF_STEADY, PROF_SENDER_GAPS,
                                     PROF_RECEIVER_STALLS, PROF_BOTH};

    two_segment_packet_framer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------------------
    // Predictor: every byte goes into the running sum, checksum slot included.
    // ---------------------------------------------------------------------------
    function automatic void put_byte(logic [7:0] value, logic last);
        frame_bytes_due.push_back('{value: value, last: last});
        frm_sum = frm_sum + value;
    endfunction

    // Closing part: F3, four zeros, checksum (with the FD FD pair counted), FD FD.
    function automatic void put_tail();
        logic [7:0] check;
        put_byte(MARK_SEG2_END, 1'b0);
        repeat (4) put_byte(8'h00, 1'b0);
        check = frm_sum + MARK_CLOSE + MARK_CLOSE;
        put_byte(check, 1'b0);
        put_byte(MARK_CLOSE, 1'b0);
        put_byte(MARK_CLOSE, 1'b1);
        frm_segment = SEG_IDLE;
        frm_left = '0;
        frm_sum = '0;
    endfunction

    // Between the segments; an empty second segment goes straight to the tail.
    function automatic void put_middle();
        put_byte(MARK_SEG1_END, 1'b0);
        put_byte(MARK_SEG2_START, 1'b0);
        put_byte(frm_len_two[7:0], 1'b0);
        put_byte(frm_len_two[15:8], 1'b0);
        if (frm_len_two == 16'd0)
            put_tail();
        else
        begin
            frm_segment = SEG_TWO;
            frm_left = frm_len_two;
        end
    endfunction

    function automatic void frame_beat(beat_t b);
        if (b.opcode == OP_START)
        begin
            // A start always begins afresh, abandoning any open packet.
            frm_sum = '0;
            frm_len_two = b.length_two;
            put_byte(b.packet_type, 1'b0);
            put_byte(b.packet_type, 1'b0);
            put_byte(b.mode_byte, 1'b0);
            put_byte(MARK_SEG1_START, 1'b0);
            put_byte(b.length_one[7:0], 1'b0);
            put_byte(b.length_one[15:8], 1'b0);
            if (b.length_one == 16'd0)
                put_middle();
            else
            begin
                frm_segment = SEG_ONE;
                frm_left = b.length_one;
            end
        end
        else if (frm_segment != SEG_IDLE)
        begin
            put_byte(b.data_byte, 1'b0);
            frm_left = frm_left - 16'd1;
            if (frm_left == 16'd0)
            begin
                if (frm_segment == SEG_ONE)
                    put_middle();
                else
                    put_tail();
            end
        end
        // A data beat outside a packet is dropped and predicts nothing.
    endfunction

    // ---------------------------------------------------------------------------
    // Stimulus building blocks. Fields a beat does not use are random noise.
    // ---------------------------------------------------------------------------
    function automatic beat_t noise_beat(traffic_e tr, logic op);
        beat_t b;
        b.wait_drain = 1'b0;
        b.hold_output = 1'b0;
        b.traffic = tr;
        b.opcode = op;
        b.packet_type = 8'($urandom);
        b.mode_byte = 8'($urandom);
        b.length_one = 16'($urandom);
        b.length_two = 16'($urandom);
        b.data_byte = 8'($urandom);
        return b;
    endfunction

    function automatic void push_start(traffic_e tr, logic [7:0] ptype, logic [7:0] mode,
                                       logic [15:0] len_one, logic [15:0] len_two);
        beat_t b;
        b = noise_beat(tr, OP_START);
        b.packet_type = ptype;
        b.mode_byte = mode;
        b.length_one = len_one;
        b.length_two = len_two;
        pending_beats.push_back(b);
    endfunction

    function automatic void push_data(traffic_e tr, logic [7:0] value);
        beat_t b;
        b = noise_beat(tr, OP_DATA);
        b.data_byte = value;
        pending_beats.push_back(b);
    endfunction

    // Mostly short segments so that framing bytes and segment ends come often.
    function automatic logic [15:0] pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 16'($urandom_range(4));
        else if (roll < 95)
            return 16'($urandom_range(16, 5));
        return 16'($urandom_range(40, 17));
    endfunction

    // ---------------------------------------------------------------------------
    // Driver: offers the queued beats, predicts each one as it is accepted.
    // ---------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic  take_next;
        int    idle_pct;
        beat_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            take_next = !s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                frame_beat(offered);
                take_next = 1'b1;
            end
            if (take_next)
            begin
                idle_pct = 0;
                if (pending_beats.size() != 0)
                begin
                    case (pending_beats[0].traffic)
                        PROF_SENDER_GAPS: idle_pct = 88;
                        PROF_BOTH:        idle_pct = 36;
                        default:          idle_pct = 0;
                    endcase
                end
                if (pending_beats.size() != 0
                    && !(pending_beats[0].wait_drain && frame_bytes_due.size() != 0)
                    && $urandom_range(99) >= idle_pct)
                begin
                    nxt = pending_beats.pop_front();
                    offered = nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= nxt.opcode;
                    s_axis_tdata <= {nxt.data_byte, nxt.length_two, nxt.length_one,
                                     nxt.mode_byte, nxt.packet_type};
                    traffic <= nxt.traffic;
                    if (nxt.hold_output)
                        hold_toggle <= !hold_toggle;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Receiver: random stalls by profile, plus a long hold-off on request so that
    // the job queue fills and the block pushes back on its input.
    // ---------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        int stall_pct;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_seen != hold_toggle)
        begin
            hold_seen <= hold_toggle;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (traffic)
                PROF_RECEIVER_STALLS: stall_pct = 88;
                PROF_BOTH:            stall_pct = 36;
                default:              stall_pct = 0;
            endcase
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------------------
    // Monitor: each output beat against the oldest byte due.
    // ---------------------------------------------------------------------------
    function automatic void note_mismatch(string what, logic [8:0] want, logic [8:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endfunction

    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frame_bytes_due.size() == 0)
                note_mismatch("unexpected beat", 9'bx, {m_axis_tlast, m_axis_tdata});
            else
            begin
                want = frame_bytes_due.pop_front();
                if (m_axis_tdata !== want.value)
                    note_mismatch("out_byte", 9'(want.value), 9'(m_axis_tdata));
                if (m_axis_tlast !== want.last)
                    note_mismatch("end_of_packet", 9'(want.last), 9'(m_axis_tlast));
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Test sequence.
    // ---------------------------------------------------------------------------
    initial
    begin
        int          first;
        int          counted;
        int          roll;
        int          extra;
        logic [15:0] len_one;
        logic [15:0] len_two;
        traffic_e    tr;

        // Directed part, no idling.
        push_data(PROF_STEADY, 8'hFF);                         // dropped: no packet open
        push_start(PROF_STEADY, 8'h00, 8'h00, 16'd0, 16'd0);   // both segments empty
        push_start(PROF_STEADY, 8'hFF, 8'hFF, 16'd0, 16'd1);   // empty first segment
        push_data(PROF_STEADY, 8'h00);
        push_start(PROF_STEADY, 8'hA5, 8'h5A, 16'd1, 16'd0);   // empty second segment
        push_data(PROF_STEADY, 8'hFF);
        push_start(PROF_STEADY, 8'h3C, 8'hC3, 16'hFFFF, 16'hFFFF);
        push_data(PROF_STEADY, 8'h12);
        push_data(PROF_STEADY, 8'hED);                         // abandoned in segment one
        push_start(PROF_STEADY, 8'h81, 8'h7E, 16'd1, 16'd2);
        push_data(PROF_STEADY, 8'h01);
        push_data(PROF_STEADY, 8'h80);                         // abandoned in segment two
        push_start(PROF_STEADY, 8'h42, 8'h24, 16'd2, 16'd1);
        push_data(PROF_STEADY, 8'hAA);
        push_data(PROF_STEADY, 8'h55);
        push_data(PROF_STEADY, 8'hC0);
        push_data(PROF_STEADY, 8'h55);                         // dropped again

        // Random part, one traffic profile per phase. Each phase starts after the
        // previous one has fully drained, and pauses once more in its middle.
        for (int p = 0; p < 4; p++)
        begin
            tr = phase_order[p];
            first = pending_beats.size();
            counted = 0;
            while (counted < PHASE_BEATS)
            begin
                roll = $urandom_range(99);
                if (roll < 75)
                begin
                    len_one = pick_length();
                    len_two = pick_length();
                    push_start(tr, 8'($urandom), 8'($urandom), len_one, len_two);
                    repeat (int'(len_one) + int'(len_two)) push_data(tr, 8'($urandom));
                    counted += 1 + int'(len_one) + int'(len_two);
                end
                else if (roll < 85)
                begin
                    push_data(tr, 8'($urandom));               // stray byte, usually dropped
                    counted += 1;
                end
                else
                begin
                    // Broken packet: random lengths, cut short by the next start.
                    extra = $urandom_range(3);
                    push_start(tr, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
                    repeat (extra) push_data(tr, 8'($urandom));
                    counted += 1 + extra;
                end
            end
            pending_beats[first].wait_drain = 1'b1;
            pending_beats[first + (pending_beats.size() - first) / 2].wait_drain = 1'b1;
            if (tr == PROF_STEADY)
                pending_beats[first].hold_output = 1'b1;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || s_axis_tvalid || frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && frame_bytes_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
